[hw/rtl/csp_pkg.sv]
// ---------------------------------------------------------------------------
// csp_pkg
// Shared widths, register indexes and sequencer states for the cardinal
// spline path interpolator and its coefficient divider.
// ---------------------------------------------------------------------------
package csp_pkg;

    // Coordinates and configuration
    localparam int COORD_W      = 16;
    localparam int MAX_SEGMENTS = 31;
    localparam int TEN_W        = 17;
    localparam int SEG_W        = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = (TEN_W > SEG_W) ? TEN_W : SEG_W;

    localparam logic [TEN_W-1:0] TENSION_RESET = TEN_W'(32768);
    localparam logic [SEG_W-1:0] SEG_RESET     = SEG_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_TENSION  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = CFG_IDX_W'(1);

    // Step counter and polynomial terms
    localparam int J_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int SQ_W   = 2 * J_W;
    localparam int CUBE_W = 3 * J_W;
    localparam int E_W    = CUBE_W + 3;
    localparam int P_W    = E_W + TEN_W;

    // Basis weights: Q24, one unity shift of 16 and a pre-scale of 8
    localparam int FRAC        = 24;
    localparam int UNITY_SHIFT = 16;
    localparam int PRE_SHIFT   = FRAC - UNITY_SHIFT;
    localparam int CW          = FRAC + 3;
    localparam int DVD_W       = P_W + PRE_SHIFT + 2;

    // Shared multiplier
    localparam int MA_W = CW + 1;
    localparam int MB_W = (COORD_W > TEN_W + 1) ? COORD_W : TEN_W + 1;
    localparam int MP_W = CW + COORD_W;
    localparam int ACC_W = MP_W + 2;

    // Coefficient cache: four weights per step
    localparam int COEF_DEPTH = MAX_SEGMENTS * 4;
    localparam int COEF_AW    = J_W + 2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ECHO,
        ST_SPAN_INIT,
        ST_MUL_S2,
        ST_MUL_S3,
        ST_J_START,
        ST_MUL_J2,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_DIFF,
        ST_MUL_P0,
        ST_MUL_P3,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CREAD,
        ST_BLEND,
        ST_OUT
    } t_state;

endpackage

[hw/rtl/cardinal_spline_path_interpolator.sv]
// ---------------------------------------------------------------------------
// cardinal_spline_path_interpolator
// Cardinal spline path generator: control points in, interpolated path
// points out, built around one shared multiplier and a serial divider.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_stall    i_point_x, i_point_y, i_last_point
//   out       source     o_out_valid / i_out_stall  o_path_x, o_path_y, o_run_last,
//                                                   o_path_done
//   cfg       sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One control point takes one request and then up to two spans of
// segment_count points. A path point reads its basis weights from the
// coefficient cache when they are there and otherwise computes them (four
// 27-step divisions); the cache is refilled on the first span after reset
// or after any configuration write. The input stays stalled until the last
// result of a request is in the output register. Reset is synchronous and
// clears the window fill count, the cache flag and the output valid.
// ---------------------------------------------------------------------------
module cardinal_spline_path_interpolator (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [csp_pkg::COORD_W-1:0]      i_point_x,
    input  logic signed [csp_pkg::COORD_W-1:0]      i_point_y,
    input  logic                                    i_last_point,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [csp_pkg::COORD_W-1:0]      o_path_x,
    output logic signed [csp_pkg::COORD_W-1:0]      o_path_y,
    output logic                                    o_run_last,
    output logic                                    o_path_done,
    input  logic                                    i_cfg_we,
    input  logic        [csp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic        [csp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import csp_pkg::*;

    t_state r_state, n_state;

    // configuration and path state
    logic [TEN_W-1:0]           r_tension;
    logic [SEG_W-1:0]           r_seg;
    logic                       r_coef_ok;
    logic [1:0]                 r_seen;
    logic signed [COORD_W-1:0]  r_wx [3];
    logic signed [COORD_W-1:0]  r_wy [3];

    // current request
    logic signed [COORD_W-1:0]  r_x, r_y;
    logic                       r_last;
    logic signed [COORD_W-1:0]  r_px [4];
    logic signed [COORD_W-1:0]  r_py [4];
    logic                       r_span_more;
    logic                       r_echo;

    // span sequencing and arithmetic
    logic [J_W-1:0]             r_s, r_j;
    logic [SQ_W-1:0]            r_s2, r_j2;
    logic [CUBE_W-1:0]          r_s3, r_a, r_b, r_c;
    logic signed [E_W-1:0]      r_e0, r_e3;
    logic signed [P_W-1:0]      r_p0, r_p3;
    logic [1:0]                 r_i;
    logic [3:0]                 r_k;
    logic signed [CW-1:0]       r_coef [4];
    logic signed [MP_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]    r_acc [2];

    // coefficient cache
    logic [CW-1:0]              r_coef_mem [COEF_DEPTH];
    logic [CW-1:0]              r_mem_q;

    // output register
    logic                       r_out_valid;
    logic signed [COORD_W-1:0]  r_out_x, r_out_y;
    logic                       r_out_run_last, r_out_done;

    // combinational
    logic                       accept;
    logic                       out_free;
    logic                       out_load;
    logic                       span_last;
    logic [J_W-1:0]             s_eff;
    logic [J_W-1:0]             jm1;
    logic [3:0]                 km1;
    t_state                     span_exit;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [MA_W+MB_W-1:0] prod;
    logic signed [E_W-1:0]      e_a, e_b, e_c;
    logic signed [DVD_W-1:0]    d_a, d_b, d_s3, d_p0, d_p3, d_num;
    logic signed [DVD_W-1:0]    div_dividend;
    logic                       div_start;
    logic                       div_done;
    logic signed [CW-1:0]       div_q;
    logic                       mem_we;
    logic [COEF_AW-1:0]         wr_addr, rd_addr;
    logic signed [ACC_W-1:0]    rnd_x, rnd_y;

    function automatic logic signed [COORD_W-1:0] f_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            f_sat = hi[COORD_W-1:0];
        end else if (v < lo) begin
            f_sat = lo[COORD_W-1:0];
        end else begin
            f_sat = v[COORD_W-1:0];
        end
    endfunction

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == ST_ECHO || r_state == ST_OUT) && out_free;
    assign span_last  = (r_j == r_s);
    assign s_eff      = (r_seg > SEG_W'(MAX_SEGMENTS)) ? J_W'(MAX_SEGMENTS) : J_W'(r_seg);
    assign jm1        = r_j - J_W'(1);
    assign km1        = r_k - 4'd1;
    assign div_start  = (r_state == ST_DIV_START);
    assign mem_we     = (r_state == ST_DIV_WAIT) && div_done;
    assign wr_addr    = {jm1, r_i};
    assign rd_addr    = {jm1, r_k[1:0]};

    // where a finished span goes next
    always_comb begin
        if (r_span_more) begin
            span_exit = ST_SPAN_INIT;
        end else if (r_echo) begin
            span_exit = ST_ECHO;
        end else begin
            span_exit = ST_IDLE;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_seen == 2'd0) begin
                        n_state = ST_ECHO;
                    end else if (r_seen >= 2'd2 || i_last_point) begin
                        n_state = ST_SPAN_INIT;
                    end
                end
            end
            ST_ECHO: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_SPAN_INIT: begin
                if (s_eff == '0) begin
                    n_state = span_exit;
                end else if (r_coef_ok) begin
                    n_state = ST_J_START;
                end else begin
                    n_state = ST_MUL_S2;
                end
            end
            ST_MUL_S2:    n_state = ST_MUL_S3;
            ST_MUL_S3:    n_state = ST_J_START;
            ST_J_START:   n_state = r_coef_ok ? ST_CREAD : ST_MUL_J2;
            ST_MUL_J2:    n_state = ST_MUL_A;
            ST_MUL_A:     n_state = ST_MUL_B;
            ST_MUL_B:     n_state = ST_MUL_C;
            ST_MUL_C:     n_state = ST_DIFF;
            ST_DIFF:      n_state = ST_MUL_P0;
            ST_MUL_P0:    n_state = ST_MUL_P3;
            ST_MUL_P3:    n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) n_state = (r_i == 2'd3) ? ST_BLEND : ST_DIV_START;
            end
            ST_CREAD: begin
                if (r_k == 4'd4) n_state = ST_BLEND;
            end
            ST_BLEND: begin
                if (r_k == 4'd8) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) n_state = span_last ? span_exit : ST_J_START;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MUL_S2: begin mul_a = MA_W'(r_s);  mul_b = MB_W'(r_s); end
            ST_MUL_S3: begin mul_a = MA_W'(r_s2); mul_b = MB_W'(r_s); end
            ST_MUL_J2: begin mul_a = MA_W'(r_j);  mul_b = MB_W'(r_j); end
            ST_MUL_A:  begin mul_a = MA_W'(r_j2); mul_b = MB_W'(r_j); end
            ST_MUL_B:  begin mul_a = MA_W'(r_j2); mul_b = MB_W'(r_s); end
            ST_MUL_C:  begin mul_a = MA_W'(r_s2); mul_b = MB_W'(r_j); end
            ST_MUL_P0: begin mul_a = MA_W'(r_e0); mul_b = MB_W'(r_tension); end
            ST_MUL_P3: begin mul_a = MA_W'(r_e3); mul_b = MB_W'(r_tension); end
            ST_BLEND: begin
                mul_a = MA_W'(r_coef[r_k[1:0]]);
                mul_b = r_k[2] ? MB_W'(r_py[r_k[1:0]]) : MB_W'(r_px[r_k[1:0]]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // weight numerators: with a = j^3, b = j^2 s, c = j s^2
    //   e0 = 2b - a - c, e3 = a - b
    //   n0 = T e0, n3 = T e3
    //   n1 = U (2a - 3b + s^3) - T e3, n2 = U (3b - 2a) - T e0
    always_comb begin
        e_a  = E_W'(r_a);
        e_b  = E_W'(r_b);
        e_c  = E_W'(r_c);
        d_a  = DVD_W'(r_a);
        d_b  = DVD_W'(r_b);
        d_s3 = DVD_W'(r_s3);
        d_p0 = DVD_W'(r_p0);
        d_p3 = DVD_W'(r_p3);
        case (r_i)
            2'd0:    d_num = d_p0;
            2'd1:    d_num = (((d_a <<< 1) - (d_b + (d_b <<< 1)) + d_s3) <<< UNITY_SHIFT) - d_p3;
            2'd2:    d_num = (((d_b + (d_b <<< 1)) - (d_a <<< 1)) <<< UNITY_SHIFT) - d_p0;
            default: d_num = d_p3;
        endcase
        div_dividend = (d_num <<< PRE_SHIFT) + (d_s3 >>> 1);
    end

    csp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_s3),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // coefficient cache
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_coef_mem[wr_addr] <= div_q;
        end
        r_mem_q <= r_coef_mem[rd_addr];
    end

    // round half up, then saturate
    always_comb begin
        rnd_x = (r_acc[0] + (ACC_W'(1) <<< (FRAC - 1))) >>> FRAC;
        rnd_y = (r_acc[1] + (ACC_W'(1) <<< (FRAC - 1))) >>> FRAC;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension   <= TENSION_RESET;
            r_seg       <= SEG_RESET;
            r_coef_ok   <= 1'b0;
            r_seen      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TENSION:  r_tension <= i_cfg_data[TEN_W-1:0];
                    REG_SEGMENTS: r_seg     <= i_cfg_data[SEG_W-1:0];
                    default: ;
                endcase
                r_coef_ok <= 1'b0;
            end else if (r_state == ST_OUT && out_free && span_last) begin
                r_coef_ok <= 1'b1;
            end

            if (accept) begin
                if (i_last_point) begin
                    r_seen <= 2'd0;
                end else if (r_seen != 2'd3) begin
                    r_seen <= r_seen + 2'd1;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= i_point_x;
            r_y    <= i_point_y;
            r_last <= i_last_point;
            r_echo <= i_last_point;
            r_span_more <= (r_seen >= 2'd2) && i_last_point;
            if (r_seen >= 2'd2) begin
                r_px <= '{r_wx[0], r_wx[1], r_wx[2], i_point_x};
                r_py <= '{r_wy[0], r_wy[1], r_wy[2], i_point_y};
            end else begin
                r_px <= '{r_wx[1], r_wx[2], i_point_x, i_point_x};
                r_py <= '{r_wy[1], r_wy[2], i_point_y, i_point_y};
            end
            if (r_seen == 2'd0) begin
                r_wx <= '{i_point_x, i_point_x, i_point_x};
                r_wy <= '{i_point_y, i_point_y, i_point_y};
            end else if (i_last_point) begin
                r_wx <= '{'0, '0, '0};
                r_wy <= '{'0, '0, '0};
            end else begin
                r_wx <= '{r_wx[1], r_wx[2], i_point_x};
                r_wy <= '{r_wy[1], r_wy[2], i_point_y};
            end
        end

        case (r_state)
            ST_SPAN_INIT: begin
                r_s <= s_eff;
                r_j <= J_W'(1);
                if (s_eff == '0 && r_span_more) begin
                    // step to the closing span
                    r_px <= '{r_px[1], r_px[2], r_px[3], r_px[3]};
                    r_py <= '{r_py[1], r_py[2], r_py[3], r_py[3]};
                    r_span_more <= 1'b0;
                end
            end
            ST_MUL_S2: r_s2 <= prod[SQ_W-1:0];
            ST_MUL_S3: r_s3 <= prod[CUBE_W-1:0];
            ST_J_START: begin
                r_k <= 4'd0;
                r_i <= 2'd0;
            end
            ST_MUL_J2: r_j2 <= prod[SQ_W-1:0];
            ST_MUL_A:  r_a  <= prod[CUBE_W-1:0];
            ST_MUL_B:  r_b  <= prod[CUBE_W-1:0];
            ST_MUL_C:  r_c  <= prod[CUBE_W-1:0];
            ST_DIFF: begin
                r_e0 <= (e_b <<< 1) - e_a - e_c;
                r_e3 <= e_a - e_b;
            end
            ST_MUL_P0: r_p0 <= prod[P_W-1:0];
            ST_MUL_P3: r_p3 <= prod[P_W-1:0];
            ST_DIV_WAIT: begin
                if (div_done) begin
                    r_coef[r_i] <= div_q;
                    r_i <= r_i + 2'd1;
                    r_k <= 4'd0;
                    r_acc <= '{'0, '0};
                end
            end
            ST_CREAD: begin
                if (r_k != 4'd0) begin
                    r_coef[km1[1:0]] <= r_mem_q;
                end
                if (r_k == 4'd4) begin
                    r_k <= 4'd0;
                    r_acc <= '{'0, '0};
                end else begin
                    r_k <= r_k + 4'd1;
                end
            end
            ST_BLEND: begin
                if (r_k != 4'd8) begin
                    r_prod <= prod[MP_W-1:0];
                    r_k <= r_k + 4'd1;
                end
                if (r_k != 4'd0) begin
                    r_acc[km1[2]] <= r_acc[km1[2]] + ACC_W'(r_prod);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_x        <= f_sat(rnd_x);
                    r_out_y        <= f_sat(rnd_y);
                    r_out_run_last <= span_last && !r_span_more && !r_echo;
                    r_out_done     <= 1'b0;
                    if (!span_last) begin
                        r_j <= r_j + J_W'(1);
                    end else if (r_span_more) begin
                        r_px <= '{r_px[1], r_px[2], r_px[3], r_px[3]};
                        r_py <= '{r_py[1], r_py[2], r_py[3], r_py[3]};
                        r_span_more <= 1'b0;
                    end
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    r_out_x        <= r_x;
                    r_out_y        <= r_y;
                    r_out_run_last <= 1'b1;
                    r_out_done     <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_path_x    = r_out_x;
    assign o_path_y    = r_out_y;
    assign o_run_last  = r_out_run_last;
    assign o_path_done = r_out_done;

endmodule

[hw/rtl/csp_div.sv]
// ---------------------------------------------------------------------------
// csp_div
// Radix-2 restoring divider with floor rounding for signed dividends.
// One quotient bit per cycle; the quotient must fit in CW-1 magnitude bits.
// ---------------------------------------------------------------------------
module csp_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [csp_pkg::DVD_W-1:0]     i_dividend,
    input  logic        [csp_pkg::CUBE_W-1:0]    i_divisor,
    output logic                                 o_done,
    output logic signed [csp_pkg::CW-1:0]        o_quotient
);
    import csp_pkg::*;

    localparam int CNT_W = $clog2(CW + 1);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic [CUBE_W-1:0]    r_rem;
    logic [CW-1:0]        r_low;

    logic [DVD_W-1:0]     mag;
    logic [CUBE_W:0]      trial;
    logic                 ge;
    logic [CUBE_W:0]      diff;

    // floor(a/d) for negative a equals ~((~a)/d)
    always_comb begin
        mag   = i_dividend[DVD_W-1] ? ~i_dividend : i_dividend;
        trial = {r_rem, r_low[CW-1]};
        ge    = (trial >= {1'b0, i_divisor});
        diff  = trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DVD_W-1];
            r_rem <= mag[CW+CUBE_W-1:CW];
            r_low <= mag[CW-1:0];
            r_cnt <= CNT_W'(CW);
        end else if (r_busy) begin
            r_rem <= ge ? diff[CUBE_W-1:0] : trial[CUBE_W-1:0];
            r_low <= {r_low[CW-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? ~r_low : r_low;

endmodule
